// ===== src/fcm_pkg.sv =====
// Shared types and constants for the FAT12 cluster chain manager.
// Holds the table geometry, operation and status codes and the RAM port structs.
// Has no dependencies of its own.
package fcm_pkg;

   localparam int ADDR_W  = 12;
   localparam int ENTRY_W = 12;
   localparam int COUNT_W = 13;
   localparam int DEPTH   = 1 << ADDR_W;

   localparam logic [COUNT_W-1:0] MAX_ENTRIES = 13'd4096;

   localparam logic [ENTRY_W-1:0] FIRST_DATA = 12'h002;
   localparam logic [ENTRY_W-1:0] END_LOW    = 12'hFF8;
   localparam logic [ENTRY_W-1:0] CHAIN_END  = 12'hFFF;

   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_ALLOC = 2'd2;
   localparam logic [1:0] OP_FREE  = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_SPACE = 2'd1;
   localparam logic [1:0] ST_BOUND    = 2'd2;

   typedef struct packed {
      logic               en;
      logic [ADDR_W-1:0]  addr;
      logic [ENTRY_W-1:0] data;
   } wr_port_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } rd_port_type;

endpackage

// ===== src/fat12_cluster_chain_manager.sv =====
// Top level of the FAT12 cluster chain manager: sequencer around the allocation table RAM.
// Depends on fcm_pkg and fcm_ram.
//
// Channel   Direction  Handshake                   Word
// request   in         start high, busy low        req_opcode, req_cluster, req_entry_value,
//                                                  req_cluster_request
// response  out        rsp_strobe, one cycle       rsp_result_value, rsp_status,
//                                                  rsp_clusters_touched
// csr       in         csr_write_enable            csr_write_data (cluster_count)
//
// A read answers via S_READ and the response register, a write via that register alone.
// An allocate scans clusters up to the scan end and, when it must be undone, walks the linked
// clusters from the first and clears each; a free walks the chain and clears each step.
// Both walks are bound by the single read port, with write data forwarded to a read of the
// same entry in the same cycle. After reset the table is cleared entry by entry with busy high.
// The receiver cannot stall; each response word is shown for exactly one cycle.
module fat12_cluster_chain_manager
   import fcm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_opcode,
   input  logic [ADDR_W-1:0]  req_cluster,
   input  logic [ENTRY_W-1:0] req_entry_value,
   input  logic [ENTRY_W-1:0] req_cluster_request,
   output logic               rsp_strobe,
   output logic [ENTRY_W-1:0] rsp_result_value,
   output logic [1:0]         rsp_status,
   output logic [COUNT_W-1:0] rsp_clusters_touched,
   input  logic               csr_write_enable,
   input  logic [ENTRY_W-1:0] csr_write_data
);

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_READ, S_SCAN, S_TERM, S_UNDO, S_FREE
   } state_type;

   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  clr_ff, clr_in;
   logic [ENTRY_W-1:0] cluster_count_ff;
   logic [ENTRY_W-1:0] want_ff, want_in;
   logic [ENTRY_W-1:0] last_ff, last_in;
   logic [COUNT_W-1:0] rc_ff, rc_in;
   logic               ev_valid_ff, ev_valid_in;
   logic [ADDR_W-1:0]  ev_addr_ff, ev_addr_in;
   logic [ENTRY_W-1:0] got_ff, got_in;
   logic [ADDR_W-1:0]  first_ff, first_in;
   logic [ADDR_W-1:0]  prev_ff, prev_in;
   logic [ADDR_W-1:0]  cur_ff, cur_in;
   logic [COUNT_W-1:0] steps_ff, steps_in;
   logic               fwd_valid_ff, fwd_valid_in;
   logic [ENTRY_W-1:0] fwd_data_ff;
   logic               rsp_strobe_ff, rsp_strobe_in;
   logic [ENTRY_W-1:0] rsp_value_ff, rsp_value_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0] rsp_touched_ff, rsp_touched_in;

   wr_port_type        wr;
   rd_port_type        rd;
   logic [ENTRY_W-1:0] ram_data;
   logic [ENTRY_W-1:0] data;
   logic               issue;
   logic               found;

   fcm_ram u_ram (
      .clock   (clock),
      .wr      (wr),
      .rd      (rd),
      .rd_data (ram_data)
   );

   assign data = fwd_valid_ff ? fwd_data_ff : ram_data;
   assign fwd_valid_in = wr.en && rd.en && (wr.addr == rd.addr);

   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      want_in        = want_ff;
      last_in        = last_ff;
      rc_in          = rc_ff;
      ev_valid_in    = ev_valid_ff;
      ev_addr_in     = ev_addr_ff;
      got_in         = got_ff;
      first_in       = first_ff;
      prev_in        = prev_ff;
      cur_in         = cur_ff;
      steps_in       = steps_ff;
      rsp_strobe_in  = 1'b0;
      rsp_value_in   = rsp_value_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_touched_in = rsp_touched_ff;
      wr             = '0;
      rd             = '0;
      issue          = 1'b0;
      found          = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            wr.en   = 1'b1;
            wr.addr = clr_ff;
            wr.data = '0;
            clr_in  = clr_ff + 1'b1;
            if (&clr_ff) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               unique case (req_opcode)
                  OP_READ: begin
                     rd.en    = 1'b1;
                     rd.addr  = req_cluster;
                     state_in = S_READ;
                  end
                  OP_WRITE: begin
                     wr.en          = 1'b1;
                     wr.addr        = req_cluster;
                     wr.data        = req_entry_value;
                     rsp_strobe_in  = 1'b1;
                     rsp_value_in   = '0;
                     rsp_status_in  = ST_OK;
                     rsp_touched_in = '0;
                  end
                  OP_ALLOC: begin
                     if (req_cluster_request == '0) begin
                        rsp_strobe_in  = 1'b1;
                        rsp_value_in   = '0;
                        rsp_status_in  = ST_OK;
                        rsp_touched_in = '0;
                     end else begin
                        want_in     = req_cluster_request;
                        last_in     = (&cluster_count_ff) ? cluster_count_ff
                                                          : cluster_count_ff + 1'b1;
                        rc_in       = {1'b0, FIRST_DATA};
                        ev_valid_in = 1'b0;
                        got_in      = '0;
                        first_in    = '0;
                        prev_in     = '0;
                        state_in    = S_SCAN;
                     end
                  end
                  OP_FREE: begin
                     if (req_cluster >= FIRST_DATA && req_cluster < END_LOW) begin
                        rd.en    = 1'b1;
                        rd.addr  = req_cluster;
                        cur_in   = req_cluster;
                        steps_in = '0;
                        state_in = S_FREE;
                     end else begin
                        rsp_strobe_in  = 1'b1;
                        rsp_value_in   = '0;
                        rsp_status_in  = ST_OK;
                        rsp_touched_in = '0;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_READ: begin
            rsp_strobe_in  = 1'b1;
            rsp_value_in   = data;
            rsp_status_in  = ST_OK;
            rsp_touched_in = '0;
            state_in       = S_IDLE;
         end
         S_SCAN: begin
            issue       = (rc_ff <= {1'b0, last_ff});
            rd.en       = issue;
            rd.addr     = rc_ff[ADDR_W-1:0];
            ev_valid_in = issue;
            ev_addr_in  = rc_ff[ADDR_W-1:0];
            if (issue) begin
               rc_in = rc_ff + 1'b1;
            end
            found = ev_valid_ff && (data == '0);
            if (found) begin
               if (got_ff != '0) begin
                  wr.en   = 1'b1;
                  wr.addr = prev_ff;
                  wr.data = ev_addr_ff;
               end else begin
                  first_in = ev_addr_ff;
               end
               prev_in = ev_addr_ff;
               got_in  = got_ff + 1'b1;
               if (got_in == want_ff) begin
                  state_in = S_TERM;
               end
            end else if (!ev_valid_ff && !issue) begin
               if (got_ff == '0) begin
                  rsp_strobe_in  = 1'b1;
                  rsp_value_in   = '0;
                  rsp_status_in  = ST_NO_SPACE;
                  rsp_touched_in = '0;
                  state_in       = S_IDLE;
               end else begin
                  rd.en    = 1'b1;
                  rd.addr  = first_ff;
                  cur_in   = first_ff;
                  state_in = S_UNDO;
               end
            end
         end
         S_TERM: begin
            wr.en          = 1'b1;
            wr.addr        = prev_ff;
            wr.data        = CHAIN_END;
            rsp_strobe_in  = 1'b1;
            rsp_value_in   = first_ff;
            rsp_status_in  = ST_OK;
            rsp_touched_in = {1'b0, got_ff};
            state_in       = S_IDLE;
         end
         S_UNDO: begin
            wr.en   = 1'b1;
            wr.addr = cur_ff;
            wr.data = '0;
            cur_in  = data;
            got_in  = got_ff - 1'b1;
            if (got_in == '0) begin
               rsp_strobe_in  = 1'b1;
               rsp_value_in   = '0;
               rsp_status_in  = ST_NO_SPACE;
               rsp_touched_in = '0;
               state_in       = S_IDLE;
            end else begin
               rd.en   = 1'b1;
               rd.addr = data;
            end
         end
         S_FREE: begin
            wr.en    = 1'b1;
            wr.addr  = cur_ff;
            wr.data  = '0;
            cur_in   = data;
            steps_in = steps_ff + 1'b1;
            if (data >= FIRST_DATA && data < END_LOW) begin
               if (steps_in >= MAX_ENTRIES) begin
                  rsp_strobe_in  = 1'b1;
                  rsp_value_in   = '0;
                  rsp_status_in  = ST_BOUND;
                  rsp_touched_in = steps_in;
                  state_in       = S_IDLE;
               end else begin
                  rd.en   = 1'b1;
                  rd.addr = data;
               end
            end else begin
               rsp_strobe_in  = 1'b1;
               rsp_value_in   = '0;
               rsp_status_in  = ST_OK;
               rsp_touched_in = steps_in;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_CLEAR;
         clr_ff           <= '0;
         cluster_count_ff <= '0;
         fwd_valid_ff     <= 1'b0;
         rsp_strobe_ff    <= 1'b0;
         ev_valid_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         fwd_valid_ff  <= fwd_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
         ev_valid_ff   <= ev_valid_in;
         if (csr_write_enable) begin
            cluster_count_ff <= csr_write_data;
         end
      end
      want_ff        <= want_in;
      last_ff        <= last_in;
      rc_ff          <= rc_in;
      ev_addr_ff     <= ev_addr_in;
      got_ff         <= got_in;
      first_ff       <= first_in;
      prev_ff        <= prev_in;
      cur_ff         <= cur_in;
      steps_ff       <= steps_in;
      fwd_data_ff    <= wr.data;
      rsp_value_ff   <= rsp_value_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_touched_ff <= rsp_touched_in;
   end

   assign busy                 = (state_ff != S_IDLE);
   assign rsp_strobe           = rsp_strobe_ff;
   assign rsp_result_value     = rsp_value_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_clusters_touched = rsp_touched_ff;

   a_read_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_opcode == OP_READ |-> ##2 rsp_strobe)
      else $error("read word did not answer two cycles after acceptance");

   a_write_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_opcode == OP_WRITE |=> rsp_strobe)
      else $error("write word did not answer in the next cycle");

   a_bound_count: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status == ST_BOUND |-> rsp_clusters_touched == MAX_ENTRIES)
      else $error("walk bound reported with a wrong step count");

   a_no_space_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status == ST_NO_SPACE
         |-> rsp_result_value == '0 && rsp_clusters_touched == '0)
      else $error("failed allocation reported a cluster");

   a_quiet_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |=> !rsp_strobe)
      else $error("response during the table clear");

endmodule

// ===== src/fcm_ram.sv =====
// Allocation table storage: one write port and one read port with registered read data.
// Depends on fcm_pkg for the geometry and the port structs.
module fcm_ram
   import fcm_pkg::*;
(
   input  logic               clock,
   input  wr_port_type        wr,
   input  rd_port_type        rd,
   output logic [ENTRY_W-1:0] rd_data
);

   logic [ENTRY_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_data <= mem[rd.addr];
      end
   end

endmodule
